// ===== src/aes128rr_pkg.sv =====
package aes128rr_pkg;

  localparam int RND_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 2'd2;

  localparam logic [RND_W-1:0] ROUND_COUNT_RST = 4'd5;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_word_t;

  // state and round key that travel down the pipe together
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] key;
  } stage_t;

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits in bits 127-8i..120-8i, so byte 0 is in bits 127..120
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      t[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = t;
  endfunction

endpackage

// ===== src/aes128rr_key_step.sv =====
module aes128rr_key_step #(
  parameter logic [7:0] RC = 8'h01
) (
  input  logic [127:0] key_i,
  output logic [127:0] key_o
);

  logic [31:0] rot_w;
  logic [31:0] w0, w1, w2, w3;

  // rotword + subword on the last word, rcon on its first byte
  assign rot_w = {aes128rr_pkg::SBOX[key_i[23:16]] ^ RC,
                  aes128rr_pkg::SBOX[key_i[15:8]],
                  aes128rr_pkg::SBOX[key_i[7:0]],
                  aes128rr_pkg::SBOX[key_i[31:24]]};

  assign w0 = key_i[127:96] ^ rot_w;
  assign w1 = key_i[95:64] ^ w0;
  assign w2 = key_i[63:32] ^ w1;
  assign w3 = key_i[31:0] ^ w2;

  assign key_o = {w0, w1, w2, w3};

endmodule

// ===== src/aes128rr_round.sv =====
module aes128rr_round #(
  parameter int STAGE = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [aes128rr_pkg::RND_W-1:0]        rounds_i,
  input  logic                                  vld_i,
  input  aes128rr_pkg::stage_t                  stg_i,
  output logic                                  vld_o,
  output aes128rr_pkg::stage_t                  stg_o
);

  localparam logic [aes128rr_pkg::RND_W-1:0] STAGE_V = aes128rr_pkg::RND_W'(STAGE);

  logic                 vld_r;
  aes128rr_pkg::stage_t stg_r;
  aes128rr_pkg::stage_t stg_nxt;
  logic [127:0]         key_nxt;
  logic [127:0]         ss;

  aes128rr_key_step #(
    .RC(aes128rr_pkg::RCON[STAGE-1])
  ) u_key_step (
    .key_i(stg_i.key),
    .key_o(key_nxt)
  );

  always_comb begin
    ss = aes128rr_pkg::sub_shift(stg_i.state);
    stg_nxt.key = key_nxt;
    if (STAGE_V < rounds_i) begin
      stg_nxt.state = aes128rr_pkg::mix_columns(ss) ^ key_nxt;
    end else if (STAGE_V == rounds_i) begin
      stg_nxt.state = ss ^ key_nxt;
    end else begin
      // past the configured last round: carry the word through
      stg_nxt.state = stg_i.state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

// ===== src/aes128_reduced_round_encrypt_unit.sv =====
// a word accepted at one edge passes the stage 0 register, then one register per round, to out_word with out_valid
// throughput: one word per cycle, set by one register stage per cipher round
// busy stays low: the pipe never stalls and the receiver cannot hold results off
// reset (rst_n low, synchronous) empties the pipe, clears the key and sets round_count to 5
module aes128_reduced_round_encrypt_unit #(
  parameter int MAX_ROUNDS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  aes128rr_pkg::in_word_t                in_word,
  output logic                                  out_valid,
  output aes128rr_pkg::out_word_t               out_word,
  input  logic                                  cfg_we,
  input  logic [aes128rr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aes128rr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [aes128rr_pkg::RND_W-1:0] MAX_V = aes128rr_pkg::RND_W'(MAX_ROUNDS);

  logic [63:0]                      key_high_r;
  logic [63:0]                      key_low_r;
  logic [aes128rr_pkg::RND_W-1:0]   round_count_r;
  logic [aes128rr_pkg::RND_W-1:0]   rounds_eff;
  logic                             in_fire;

  logic                             vld_pipe [MAX_ROUNDS+1];
  aes128rr_pkg::stage_t             stg_pipe [MAX_ROUNDS+1];

  logic                             vld0_r;
  aes128rr_pkg::stage_t             stg0_r;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r    <= '0;
      key_low_r     <= '0;
      round_count_r <= aes128rr_pkg::ROUND_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aes128rr_pkg::CFG_KEY_HIGH:    key_high_r    <= cfg_data;
        aes128rr_pkg::CFG_KEY_LOW:     key_low_r     <= cfg_data;
        aes128rr_pkg::CFG_ROUND_COUNT: round_count_r <= cfg_data[aes128rr_pkg::RND_W-1:0];
        default: ;
      endcase
    end
  end

  // round count saturates into 1..MAX_ROUNDS
  always_comb begin
    if (round_count_r == '0) begin
      rounds_eff = aes128rr_pkg::RND_W'(1);
    end else if (round_count_r > MAX_V) begin
      rounds_eff = MAX_V;
    end else begin
      rounds_eff = round_count_r;
    end
  end

  // stage 0: initial add round key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    stg0_r.state <= {in_word.plain_high, in_word.plain_low} ^ {key_high_r, key_low_r};
    stg0_r.key   <= {key_high_r, key_low_r};
  end

  assign vld_pipe[0] = vld0_r;
  assign stg_pipe[0] = stg0_r;

  for (genvar k = 1; k <= MAX_ROUNDS; k++) begin : g_round
    aes128rr_round #(
      .STAGE(k)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .rounds_i(rounds_eff),
      .vld_i   (vld_pipe[k-1]),
      .stg_i   (stg_pipe[k-1]),
      .vld_o   (vld_pipe[k]),
      .stg_o   (stg_pipe[k])
    );
  end

  assign out_valid            = vld_pipe[MAX_ROUNDS];
  assign out_word.cipher_high = stg_pipe[MAX_ROUNDS].state[127:64];
  assign out_word.cipher_low  = stg_pipe[MAX_ROUNDS].state[63:0];

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##(MAX_ROUNDS+1) out_valid)
    else $error("word lost in pipe");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld0_r, MAX_ROUNDS))
    else $error("result without a word behind it");

  a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (rounds_eff >= aes128rr_pkg::RND_W'(1)) && (rounds_eff <= MAX_V))
    else $error("round count out of range");

  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
